/* hdl/tmm_pkg.sv */
// tmm_pkg: shared types, constants and helpers of the TRS model matrix block.
// Used by every module in hdl/; depends on nothing.
package tmm_pkg;

    localparam int ANG_FULL     = 23040;
    localparam int ANG_QUARTER  = 5760;
    localparam int CORDIC_STEPS = 18;
    localparam int CORDIC_GAIN  = 652032874;
    localparam int LATENCY      = CORDIC_STEPS + 7;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_z;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
    } tmm_in_t;

    typedef struct packed {
        logic signed [31:0] col0_x;
        logic signed [31:0] col0_y;
        logic signed [31:0] col0_z;
        logic signed [31:0] col1_x;
        logic signed [31:0] col1_y;
        logic signed [31:0] col1_z;
        logic signed [31:0] col2_x;
        logic signed [31:0] col2_y;
        logic signed [31:0] col2_z;
        logic signed [31:0] trans_x;
        logic signed [31:0] trans_y;
        logic signed [31:0] trans_z;
    } tmm_out_t;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [31:0] z;
        logic [1:0]         quad;
    } tmm_lane_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
    } tmm_side_t;

    typedef struct packed {
        logic                 vld;
        tmm_lane_t [2:0]      lane;
        tmm_side_t            side;
    } tmm_cell_t;

    function automatic logic signed [31:0] atan_val(input int i);
        logic signed [31:0] v;
        case (i)
            0:  v = 32'sd188743680;
            1:  v = 32'sd111421900;
            2:  v = 32'sd58872272;
            3:  v = 32'sd29884485;
            4:  v = 32'sd15000234;
            5:  v = 32'sd7507429;
            6:  v = 32'sd3754631;
            7:  v = 32'sd1877430;
            8:  v = 32'sd938729;
            9:  v = 32'sd469366;
            10: v = 32'sd234683;
            11: v = 32'sd117342;
            12: v = 32'sd58671;
            13: v = 32'sd29335;
            14: v = 32'sd14668;
            15: v = 32'sd7334;
            16: v = 32'sd3667;
            default: v = 32'sd1833;
        endcase
        return v;
    endfunction

    // Q30 times Q30, round half up to Q30
    function automatic logic signed [33:0] mul30(input logic signed [33:0] a,
                                                 input logic signed [33:0] b);
        logic signed [67:0] p;
        p = (a * b + (68'sd1 <<< 29)) >>> 30;
        return p[33:0];
    endfunction

endpackage

/* hdl/tmm_reduce.sv */
// tmm_reduce: first cell of the chain; wraps angles to one turn, splits the
// quadrant off and loads the CORDIC start values. Depends on tmm_pkg.
module tmm_reduce
    import tmm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      vld,
    input  tmm_in_t   item,
    output tmm_cell_t cell_out
);

    tmm_cell_t cell_reg;
    tmm_cell_t cell_next;

    function automatic tmm_lane_t load_lane(input logic signed [15:0] ang);
        logic signed [17:0] r;
        logic [1:0]         q;
        logic signed [17:0] t;
        tmm_lane_t          l;
        r = 18'(ang);
        if (r < 0)
            r = r + 18'(ANG_FULL);
        if (r < 0)
            r = r + 18'(ANG_FULL);
        if (r >= 18'(ANG_FULL))
            r = r - 18'(ANG_FULL);
        if (r >= 18'(3 * ANG_QUARTER))
            q = 2'd3;
        else if (r >= 18'(2 * ANG_QUARTER))
            q = 2'd2;
        else if (r >= 18'(ANG_QUARTER))
            q = 2'd1;
        else
            q = 2'd0;
        t      = r - 18'(int'(q) * ANG_QUARTER);
        l.x    = 34'(CORDIC_GAIN);
        l.y    = '0;
        l.z    = {3'b000, t[12:0], 16'b0};
        l.quad = q;
        return l;
    endfunction

    always_comb
    begin
        cell_next.vld           = vld;
        cell_next.lane[0]       = load_lane(item.angle_x);
        cell_next.lane[1]       = load_lane(item.angle_y);
        cell_next.lane[2]       = load_lane(item.angle_z);
        cell_next.side.pos_x    = item.pos_x;
        cell_next.side.pos_y    = item.pos_y;
        cell_next.side.pos_z    = item.pos_z;
        cell_next.side.scale_x  = item.scale_x;
        cell_next.side.scale_y  = item.scale_y;
        cell_next.side.scale_z  = item.scale_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cell_reg <= '0;
        else
            cell_reg <= cell_next;
    end

    assign cell_out = cell_reg;

endmodule

/* hdl/tmm_cordic_cell.sv */
// tmm_cordic_cell: one CORDIC rotation step for the three angle lanes, with
// the side payload passed along. Depends on tmm_pkg.
module tmm_cordic_cell
    import tmm_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  tmm_cell_t cell_in,
    output tmm_cell_t cell_out
);

    localparam logic signed [31:0] ATAN = atan_val(STEP);

    tmm_cell_t cell_reg;
    tmm_cell_t cell_next;

    always_comb
    begin
        cell_next = cell_in;
        for (int k = 0; k < 3; k++)
        begin
            // turn toward zero residual angle
            if (cell_in.lane[k].z >= 0)
            begin
                cell_next.lane[k].x = cell_in.lane[k].x - (cell_in.lane[k].y >>> STEP);
                cell_next.lane[k].y = cell_in.lane[k].y + (cell_in.lane[k].x >>> STEP);
                cell_next.lane[k].z = cell_in.lane[k].z - ATAN;
            end
            else
            begin
                cell_next.lane[k].x = cell_in.lane[k].x + (cell_in.lane[k].y >>> STEP);
                cell_next.lane[k].y = cell_in.lane[k].y - (cell_in.lane[k].x >>> STEP);
                cell_next.lane[k].z = cell_in.lane[k].z + ATAN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cell_reg <= '0;
        else
            cell_reg <= cell_next;
    end

    assign cell_out = cell_reg;

endmodule

/* hdl/tmm_matrix.sv */
// tmm_matrix: back end; maps quadrants to sine/cosine, forms the rotation
// entries, scales and saturates them. Six register stages. Depends on tmm_pkg.
module tmm_matrix
    import tmm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  tmm_cell_t cell_in,
    output logic      done,
    output tmm_out_t  result
);

    typedef logic signed [33:0] q30_t;

    // stage 1: sine / cosine
    logic [5:0]   vld_reg;
    tmm_side_t    side1_reg, side2_reg, side3_reg, side4_reg, side5_reg;
    q30_t         sn_reg [3];
    q30_t         cs_reg [3];
    // stage 2: first products
    q30_t         sysx_reg, cysx_reg, cycz_reg, sycz_reg, cysz_reg, sysz_reg;
    q30_t         sycx_reg, cxsz_reg, cxcz_reg, cycx_reg, nsx_reg;
    // stage 3: second products
    q30_t         p0_reg, p1_reg, p2_reg, p3_reg;
    q30_t         a0_reg, a1_reg, a2_reg, a3_reg, b0_reg, b1_reg, b2_reg, b3_reg, b4_reg;
    // stage 4: entries
    q30_t         m_reg [9];
    // stage 5: raw scaled products
    logic signed [65:0] sp_reg [9];
    tmm_out_t     result_reg;
    tmm_out_t     result_next;

    function automatic logic signed [31:0] sat_round(input logic signed [65:0] p);
        logic signed [66:0] v;
        v = (67'(p) + (67'sd1 <<< 29)) >>> 30;
        if (v > 67'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -67'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[4:0], cell_in.vld};
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            case (cell_in.lane[k].quad)
                2'd0:
                begin
                    cs_reg[k] <= cell_in.lane[k].x;
                    sn_reg[k] <= cell_in.lane[k].y;
                end
                2'd1:
                begin
                    cs_reg[k] <= -cell_in.lane[k].y;
                    sn_reg[k] <= cell_in.lane[k].x;
                end
                2'd2:
                begin
                    cs_reg[k] <= -cell_in.lane[k].x;
                    sn_reg[k] <= -cell_in.lane[k].y;
                end
                default:
                begin
                    cs_reg[k] <= cell_in.lane[k].y;
                    sn_reg[k] <= -cell_in.lane[k].x;
                end
            endcase
        end
        side1_reg <= cell_in.side;

        // index 0 = x, 1 = y, 2 = z
        sysx_reg <= mul30(sn_reg[1], sn_reg[0]);
        cysx_reg <= mul30(cs_reg[1], sn_reg[0]);
        cycz_reg <= mul30(cs_reg[1], cs_reg[2]);
        sycz_reg <= mul30(sn_reg[1], cs_reg[2]);
        cysz_reg <= mul30(cs_reg[1], sn_reg[2]);
        sysz_reg <= mul30(sn_reg[1], sn_reg[2]);
        sycx_reg <= mul30(sn_reg[1], cs_reg[0]);
        cxsz_reg <= mul30(cs_reg[0], sn_reg[2]);
        cxcz_reg <= mul30(cs_reg[0], cs_reg[2]);
        cycx_reg <= mul30(cs_reg[1], cs_reg[0]);
        nsx_reg  <= -sn_reg[0];
        side2_reg <= side1_reg;
    end

    // sz and cz are needed by stage 3, so they are registered alongside the stage 2 products
    q30_t sz_d_reg, cz_d_reg;
    always_ff @(posedge clk)
    begin
        sz_d_reg <= sn_reg[2];
        cz_d_reg <= cs_reg[2];
    end

    always_ff @(posedge clk)
    begin
        p0_reg <= mul30(sysx_reg, sz_d_reg);
        p1_reg <= mul30(sysx_reg, cz_d_reg);
        p2_reg <= mul30(cysx_reg, sz_d_reg);
        p3_reg <= mul30(cysx_reg, cz_d_reg);
        a0_reg <= cycz_reg;
        a1_reg <= cysz_reg;
        a2_reg <= sycz_reg;
        a3_reg <= sysz_reg;
        b0_reg <= sycx_reg;
        b1_reg <= cxsz_reg;
        b2_reg <= cxcz_reg;
        b3_reg <= nsx_reg;
        b4_reg <= cycx_reg;
        side3_reg <= side2_reg;

        m_reg[0] <= a0_reg + p0_reg;
        m_reg[1] <= p1_reg - a1_reg;
        m_reg[2] <= b0_reg;
        m_reg[3] <= b1_reg;
        m_reg[4] <= b2_reg;
        m_reg[5] <= b3_reg;
        m_reg[6] <= p2_reg - a2_reg;
        m_reg[7] <= a3_reg + p3_reg;
        m_reg[8] <= b4_reg;
        side4_reg <= side3_reg;

        // m_reg is row-major; column c takes scale c
        for (int e = 0; e < 9; e++)
        begin
            case (e % 3)
                0:       sp_reg[e] <= m_reg[e] * side4_reg.scale_x;
                1:       sp_reg[e] <= m_reg[e] * side4_reg.scale_y;
                default: sp_reg[e] <= m_reg[e] * side4_reg.scale_z;
            endcase
        end
        side5_reg <= side4_reg;

        result_reg <= result_next;
    end

    always_comb
    begin
        result_next.col0_x  = sat_round(sp_reg[0]);
        result_next.col0_y  = sat_round(sp_reg[3]);
        result_next.col0_z  = sat_round(sp_reg[6]);
        result_next.col1_x  = sat_round(sp_reg[1]);
        result_next.col1_y  = sat_round(sp_reg[4]);
        result_next.col1_z  = sat_round(sp_reg[7]);
        result_next.col2_x  = sat_round(sp_reg[2]);
        result_next.col2_y  = sat_round(sp_reg[5]);
        result_next.col2_z  = sat_round(sp_reg[8]);
        result_next.trans_x = side5_reg.pos_x;
        result_next.trans_y = side5_reg.pos_y;
        result_next.trans_z = side5_reg.pos_z;
    end

    assign done   = vld_reg[5];
    assign result = result_reg;

endmodule

/* hdl/trs_model_matrix.sv */
// trs_model_matrix: top level; angle reduction cell, chain of CORDIC cells
// and the matrix back end. Depends on tmm_pkg and the tmm_* modules.
//
// Use: drive item and raise start for one cycle per object. The item is
// taken at any rising edge with start high and busy low; busy stays low,
// so a new object may enter every clock.
// One result per object sits on result for exactly one cycle, marked by
// done, after the item has passed one reduction cell, 18 CORDIC cells
// and six back-end stages (summed as LATENCY in the package); results
// leave in input order.
// Throughput is one object per clock, set by the fully pipelined cell chain.
// The receiver cannot stall the block; a result not taken in its cycle is
// gone.
// Reset clears every valid flag in the chain; items in flight are dropped
// and done stays low until new items reach the end.
module trs_model_matrix
    import tmm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  tmm_in_t  item,
    output logic     done,
    output tmm_out_t result
);

    tmm_cell_t chain [CORDIC_STEPS + 1];

    assign busy = 1'b0;

    tmm_reduce u_reduce (
        .clk      (clk),
        .rst_n    (rst_n),
        .vld      (start && !busy),
        .item     (item),
        .cell_out (chain[0])
    );

    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_cell
        tmm_cordic_cell #(.STEP(g)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_in  (chain[g]),
            .cell_out (chain[g + 1])
        );
    end

    tmm_matrix u_matrix (
        .clk     (clk),
        .rst_n   (rst_n),
        .cell_in (chain[CORDIC_STEPS]),
        .done    (done),
        .result  (result)
    );

    a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted item produced no result");

    a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without accepted item");

    a_trans: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.trans_x == $past(item.pos_x, LATENCY)
              && result.trans_z == $past(item.pos_z, LATENCY)))
        else $error("translation misaligned with its item");

endmodule
